/* sv/ssb_pkg.sv */
// shared types and constants of the sprite sort and batch block
`timescale 1ns / 1ps
package ssb_pkg;

  localparam int MAX_SPRITES = 64;
  localparam int IDX_W       = $clog2(MAX_SPRITES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BANKS       = 2;
  localparam int RAM_ADDR_W  = IDX_W + 1;
  localparam int VOFF_W      = 9;
  localparam int TEX_W       = 16;
  localparam int DEP_W       = 16;

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_DEPTH_UP  = 2'd1,
    MODE_DEPTH_DN  = 2'd2,
    MODE_TEXTURE   = 2'd3
  } sort_mode_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LATCH,
    BK_SCAN,
    BK_READ,
    BK_LOAD
  } back_state_t;

  typedef struct packed {
    logic [TEX_W-1:0]        texture_id;
    logic signed [DEP_W-1:0] depth;
    logic                    last_sprite;
  } sprite_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  sprite_index;
    logic [TEX_W-1:0]  texture_out;
    logic              starts_batch;
    logic [VOFF_W-1:0] vertex_offset;
    logic              dropped_any;
    logic              last_result;
  } sprite_out_t;

  typedef struct packed {
    logic [TEX_W-1:0]        tex;
    logic signed [DEP_W-1:0] dep;
  } sprite_entry_t;

  localparam int ENTRY_W = $bits(sprite_entry_t);

  typedef struct packed {
    logic            bank;
    logic [CNT_W-1:0] count;
    logic            dropped;
    sort_mode_t      mode;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
    sprite_entry_t         data;
  } ram_wr_t;

  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

/* sv/ssb_ram.sv */
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
module ssb_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/ssb_front.sv */
// load side: stores sprites into the free bank and posts a sort job per set
`timescale 1ns / 1ps
module ssb_front import ssb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  sprite_in_t in_data,
  input  logic       job_full,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  output logic       in_full,
  output ram_wr_t    ram_wr,
  output logic       job_push,
  output job_t       job_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  sort_mode_t       mode_r, mode_nxt;
  logic             accept;
  logic             has_room;

  assign in_full  = job_full;
  assign accept   = in_push && !job_full;
  assign has_room = (count_r < CNT_W'(MAX_SPRITES));

  always_comb begin
    ram_wr.en       = accept && has_room;
    ram_wr.addr     = {bank_r, count_r[IDX_W-1:0]};
    ram_wr.data.tex = in_data.texture_id;
    ram_wr.data.dep = in_data.depth;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    mode_nxt  = mode_r;
    if (cfg_valid) begin
      mode_nxt = sort_mode_t'(cfg_data);
    end
    if (accept) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    job_push         = accept && in_data.last_sprite;
    job_data.bank    = bank_r;
    job_data.count   = count_nxt;
    job_data.dropped = ovf_nxt;
    job_data.mode    = mode_r;
    if (job_push) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      bank_nxt  = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      mode_r  <= MODE_TEXTURE;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

/* sv/ssb_job_queue.sv */
// two-entry queue of sort jobs between load side and sort side
`timescale 1ns / 1ps
module ssb_job_queue import ssb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic full,
  output logic valid,
  output job_t head
);

  job_t       slot_r [BANKS];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] used_r, used_nxt;

  assign full  = (used_r == 2'(BANKS));
  assign valid = (used_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    used_nxt   = used_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      used_nxt = used_r + 2'd1;
    end else if (pop && !push) begin
      used_nxt = used_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

endmodule

/* sv/ssb_back.sv */
// sort side: ranks each sprite by a scan of its bank, then emits in rank order
`timescale 1ns / 1ps
module ssb_back import ssb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  job_t          job,
  output logic          job_pop,
  output ram_rd_t       ram_rd,
  input  sprite_entry_t ram_rdata,
  output logic          out_empty,
  input  logic          out_pop,
  output sprite_out_t   out_data
);

  localparam int ORD_W = IDX_W + TEX_W;

  back_state_t state_r, state_nxt;

  logic [IDX_W-1:0]        i_r, j_r, p_r, rank_r;
  logic [TEX_W-1:0]        key_tex_r, prev_tex_r;
  logic signed [DEP_W-1:0] key_dep_r;
  logic [IDX_W-1:0]        n_m1;

  logic [ORD_W-1:0] ord_mem [MAX_SPRITES];
  logic [ORD_W-1:0] ord_rdata_r;
  logic             ord_wr_en, ord_rd_en;
  logic [IDX_W-1:0] ord_wr_addr;

  logic             ahead, equal, hit, scan_end, last_i, last_p, load_out;
  logic [IDX_W-1:0] rank_sum;
  logic [IDX_W-1:0] ord_index;
  logic [TEX_W-1:0] ord_tex;

  logic        out_valid_r;
  sprite_out_t out_data_r;

  assign n_m1      = IDX_W'(job.count - CNT_W'(1));
  assign scan_end  = (j_r == n_m1);
  assign last_i    = (i_r == n_m1);
  assign last_p    = (p_r == n_m1);
  assign load_out  = !out_valid_r || out_pop;
  assign ord_index = ord_rdata_r[ORD_W-1 -: IDX_W];
  assign ord_tex   = ord_rdata_r[TEX_W-1:0];

  // does the scanned sprite rank ahead of the held one
  always_comb begin
    unique case (job.mode)
      MODE_DEPTH_UP: begin
        ahead = (ram_rdata.dep < key_dep_r);
        equal = (ram_rdata.dep == key_dep_r);
      end
      MODE_DEPTH_DN: begin
        ahead = (ram_rdata.dep > key_dep_r);
        equal = (ram_rdata.dep == key_dep_r);
      end
      MODE_TEXTURE: begin
        ahead = (ram_rdata.tex < key_tex_r);
        equal = (ram_rdata.tex == key_tex_r);
      end
      default: begin
        ahead = 1'b0;
        equal = 1'b1;
      end
    endcase
    hit      = ahead || (equal && (j_r < i_r));
    rank_sum = rank_r + IDX_W'(hit);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (job_valid) state_nxt = BK_FETCH;
      BK_FETCH: state_nxt = BK_LATCH;
      BK_LATCH: state_nxt = BK_SCAN;
      BK_SCAN: begin
        if (scan_end) begin
          state_nxt = last_i ? BK_READ : BK_FETCH;
        end
      end
      BK_READ:  state_nxt = BK_LOAD;
      BK_LOAD: begin
        if (load_out) begin
          state_nxt = last_p ? BK_IDLE : BK_READ;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_rd.en   = 1'b0;
    ram_rd.addr = {job.bank, i_r};
    ord_wr_en   = 1'b0;
    ord_wr_addr = rank_sum;
    ord_rd_en   = 1'b0;
    job_pop     = 1'b0;
    unique case (state_r)
      BK_FETCH: ram_rd.en = 1'b1;
      BK_LATCH: begin
        ram_rd.en   = 1'b1;
        ram_rd.addr = {job.bank, {IDX_W{1'b0}}};
      end
      BK_SCAN: begin
        ram_rd.en   = !scan_end;
        ram_rd.addr = {job.bank, j_r + IDX_W'(1)};
        ord_wr_en   = scan_end;
      end
      BK_READ:  ord_rd_en = 1'b1;
      BK_LOAD:  job_pop = load_out && last_p;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_wr_en) begin
      ord_mem[ord_wr_addr] <= {i_r, key_tex_r};
    end
    if (ord_rd_en) begin
      ord_rdata_r <= ord_mem[p_r];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        i_r <= '0;
      end
      BK_LATCH: begin
        key_tex_r <= ram_rdata.tex;
        key_dep_r <= ram_rdata.dep;
        j_r       <= '0;
        rank_r    <= '0;
      end
      BK_SCAN: begin
        j_r    <= j_r + IDX_W'(1);
        rank_r <= rank_sum;
        if (scan_end) begin
          i_r <= i_r + IDX_W'(1);
          p_r <= '0;
        end
      end
      BK_LOAD: begin
        if (load_out) begin
          p_r        <= p_r + IDX_W'(1);
          prev_tex_r <= ord_tex;
          out_data_r.sprite_index  <= ord_index;
          out_data_r.texture_out   <= ord_tex;
          out_data_r.starts_batch  <= (p_r == '0) || (ord_tex != prev_tex_r);
          out_data_r.vertex_offset <= (VOFF_W'(p_r) << 2) + (VOFF_W'(p_r) << 1);
          out_data_r.dropped_any   <= job.dropped;
          out_data_r.last_result   <= last_p;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_LOAD && load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/sprite_sort_and_batch.sv */
// sprite sort and batch top level: load side, job queue, sorter and sprite memory
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------
//  in      | in_push / in_full      | in_data  (sprite_in_t)
//  out     | out_pop / out_empty    | out_data (sprite_out_t)
//  cfg     | cfg_valid / cfg_ready  | cfg_data (sort mode, 2 bits)
//
// a sprite request is taken in any cycle in which in_full is low; a set of
// n sprites is sorted at a pace bound by the one read port of the sprite
// memory during the rank scan, then emitted one result at a time in rank order.
// two memory banks let the next set load while the previous one sorts;
// in_full rises only when both banks hold sets not yet emitted.
// reset is synchronous and clears counters, queue and state, not memories.
`timescale 1ns / 1ps
module sprite_sort_and_batch import ssb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  sprite_in_t  in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output sprite_out_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  ram_wr_t       ram_wr;
  ram_rd_t       ram_rd;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  sprite_entry_t ram_rdata;
  logic          job_push, job_pop, job_full, job_valid;
  job_t          job_in, job_head;

  assign cfg_ready = 1'b1;
  assign ram_rdata = sprite_entry_t'(ram_rdata_raw);

  ssb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .job_full  (job_full),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_full   (in_full),
    .ram_wr    (ram_wr),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  ssb_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (RAM_ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (ram_rd.en),
    .rd_addr (ram_rd.addr),
    .rd_data (ram_rdata_raw)
  );

  ssb_job_queue u_jobs (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .full      (job_full),
    .valid     (job_valid),
    .head      (job_head)
  );

  ssb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .ram_rd    (ram_rd),
    .ram_rdata (ram_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
